[src/scm_pkg.sv]
// Shared types and constants for the stereo chorus block.
// Used by every module in src; depends on nothing else.
package scm_pkg;

  localparam int SAMPLE_BITS    = 24;
  localparam int MIX_BITS       = 16;
  localparam int CENTRE_BITS    = 18;
  localparam int DEPTH_BITS     = 18;
  localparam int STEP_BITS      = 32;
  localparam int CFG_DATA_BITS  = 32;
  localparam int CFG_INDEX_BITS = 2;
  // Signed delay offset: an 18-bit magnitude plus sign.
  localparam int OFFSET_BITS    = DEPTH_BITS + 1;
  // Quarter-wave sine entries are Q1.15 magnitudes capped at 32767.
  localparam int SINE_BITS      = 15;

  localparam logic [CFG_INDEX_BITS-1:0] CFG_MIX    = 2'd0;
  localparam logic [CFG_INDEX_BITS-1:0] CFG_CENTRE = 2'd1;
  localparam logic [CFG_INDEX_BITS-1:0] CFG_DEPTH  = 2'd2;
  localparam logic [CFG_INDEX_BITS-1:0] CFG_STEP   = 2'd3;

  localparam logic [MIX_BITS-1:0]    MIX_RESET    = 16'd0;
  localparam logic [CENTRE_BITS-1:0] CENTRE_RESET = 18'd61440;
  localparam logic [DEPTH_BITS-1:0]  DEPTH_RESET  = 18'd24576;
  localparam logic [STEP_BITS-1:0]   STEP_RESET   = 32'd44739;
  localparam logic [MIX_BITS-1:0]    MIX_FULL     = 16'h8000;

  // pi/2 in Q30, seed of the sine series.
  localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;

  localparam int LFO_LATENCY  = 5;
  localparam int LANE_LATENCY = 8;
  localparam int PIPE_LATENCY = LFO_LATENCY + LANE_LATENCY;
  localparam int CNT_BITS     = $clog2(PIPE_LATENCY);

  typedef logic signed [SAMPLE_BITS-1:0] sample_t;

  typedef struct packed {
    sample_t left_in;
    sample_t right_in;
  } in_item_t;

  typedef struct packed {
    sample_t left_out;
    sample_t right_out;
  } out_item_t;

  typedef struct packed {
    logic wr_en;
    logic wrapped;
  } lane_ctrl_t;

  typedef struct packed {
    logic load;
    logic bypass;
  } merge_ctrl_t;

endpackage

[src/scm_lfo.sv]
// Sine LFO for the chorus: phase to table index, quarter-wave lookup and delay swing.
// Depends on scm_pkg.
module scm_lfo import scm_pkg::*; #(
  parameter int TABLE_DEPTH = 256
) (
  input  logic                          clk,
  input  logic [STEP_BITS-1:0]          phase,
  input  logic [DEPTH_BITS-1:0]         sweep_depth,
  output logic signed [OFFSET_BITS-1:0] offset
);

  localparam int QUARTER    = TABLE_DEPTH / 4;
  localparam int IDX_BITS   = $clog2(TABLE_DEPTH);
  localparam int ENTRY_BITS = $clog2(QUARTER + 1);
  localparam int PP_BITS    = STEP_BITS + IDX_BITS + 1;
  localparam int SW_BITS    = DEPTH_BITS + SINE_BITS;
  localparam logic [IDX_BITS:0] Q1 = (IDX_BITS + 1)'(QUARTER);
  localparam logic [IDX_BITS:0] Q2 = (IDX_BITS + 1)'(2 * QUARTER);
  localparam logic [IDX_BITS:0] Q3 = (IDX_BITS + 1)'(3 * QUARTER);
  localparam logic [IDX_BITS:0] Q4 = (IDX_BITS + 1)'(4 * QUARTER);
  localparam logic [IDX_BITS:0] TD = (IDX_BITS + 1)'(TABLE_DEPTH);

  // Integer Taylor series for sin(pi/2 * k / QUARTER), rounded to Q1.15.
  function automatic logic [SINE_BITS-1:0] sine_entry(input int k);
    logic [63:0]        x;
    logic [63:0]        t;
    logic signed [63:0] sum;
    int                 n;
    x   = 64'(k) * HALF_PI_Q30 / QUARTER;
    t   = x;
    sum = signed'(x);
    for (n = 1; n <= 12; n++) begin
      t = (t * x) >> 30;
      t = (t * x) >> 30;
      case (n)
        1:       t = t / 6;
        2:       t = t / 20;
        3:       t = t / 42;
        4:       t = t / 72;
        5:       t = t / 110;
        6:       t = t / 156;
        7:       t = t / 210;
        8:       t = t / 272;
        9:       t = t / 342;
        10:      t = t / 420;
        11:      t = t / 506;
        default: t = t / 600;
      endcase
      if (n[0]) sum = sum - signed'(t);
      else sum = sum + signed'(t);
    end
    if (sum < 0) sum = 0;
    sum = (sum + 64'sd16384) >>> 15;
    if (sum > 64'sd32767) sum = 64'sd32767;
    return SINE_BITS'(sum);
  endfunction

  logic [SINE_BITS-1:0] sine_rom [QUARTER+1];

  for (genvar g = 0; g <= QUARTER; g++) begin : g_rom
    localparam logic [SINE_BITS-1:0] ENTRY = sine_entry(g);
    assign sine_rom[g] = ENTRY;
  end

  logic [PP_BITS-1:0]    phase_prod;
  logic [IDX_BITS-1:0]   idx;
  logic [IDX_BITS:0]     idx_x;
  logic [IDX_BITS:0]     k;
  logic [2:0]            quad_raw;
  logic [1:0]            quad;
  logic [ENTRY_BITS-1:0] entry;
  logic [ENTRY_BITS-1:0] entry_next;
  logic                  neg_s2;
  logic                  neg_s3;
  logic                  neg_s4;
  logic [SINE_BITS-1:0]  mag;
  logic [SW_BITS-1:0]    prod;
  logic [SW_BITS:0]      rounded;
  logic [DEPTH_BITS-1:0] off_mag;
  logic signed [OFFSET_BITS-1:0] offset_next;

  assign phase_prod = PP_BITS'(phase) * PP_BITS'(TD);

  // Quadrant split by comparing against the quarter boundaries.
  always_comb begin
    idx_x = {1'b0, idx};
    if (idx_x >= Q4) begin
      quad_raw = 3'd4;
      k        = idx_x - Q4;
    end else if (idx_x >= Q3) begin
      quad_raw = 3'd3;
      k        = idx_x - Q3;
    end else if (idx_x >= Q2) begin
      quad_raw = 3'd2;
      k        = idx_x - Q2;
    end else if (idx_x >= Q1) begin
      quad_raw = 3'd1;
      k        = idx_x - Q1;
    end else begin
      quad_raw = 3'd0;
      k        = idx_x;
    end
    quad       = quad_raw[1:0];
    entry_next = quad[0] ? ENTRY_BITS'(Q1 - k) : ENTRY_BITS'(k);
  end

  always_comb begin
    rounded     = (SW_BITS + 1)'(prod) + (SW_BITS + 1)'(16384);
    off_mag     = DEPTH_BITS'(rounded >> 15);
    offset_next = neg_s4 ? -signed'({1'b0, off_mag}) : signed'({1'b0, off_mag});
  end

  always_ff @(posedge clk) begin
    idx    <= phase_prod[STEP_BITS +: IDX_BITS];
    entry  <= entry_next;
    neg_s2 <= quad[1];
    mag    <= sine_rom[entry];
    neg_s3 <= neg_s2;
    prod   <= SW_BITS'(sweep_depth) * SW_BITS'(mag);
    neg_s4 <= neg_s3;
    offset <= offset_next;
  end

endmodule

[src/scm_lane.sv]
// One channel of the chorus: circular delay line, fractional read with linear
// interpolation, and dry/wet crossfade. Depends on scm_pkg.
module scm_lane import scm_pkg::*; #(
  parameter int DEPTH = 1024
) (
  input  logic                          clk,
  input  lane_ctrl_t                    ctrl,
  input  logic [$clog2(DEPTH)-1:0]      wr_index,
  input  sample_t                       wr_sample,
  input  sample_t                       dry,
  input  logic signed [OFFSET_BITS-1:0] offset,
  input  logic [CENTRE_BITS-1:0]        centre,
  input  logic [MIX_BITS-1:0]           mix_weight,
  output sample_t                       result
);

  localparam int IDX_BITS  = $clog2(DEPTH);
  localparam int POS_BITS  = IDX_BITS + 8;
  localparam int SUM_BITS  = OFFSET_BITS + 2;
  localparam int CMP_BITS  = (SUM_BITS > POS_BITS + 1) ? SUM_BITS : POS_BITS + 1;
  localparam int PROD_BITS = SAMPLE_BITS + 10;
  localparam int MIXP_BITS = SAMPLE_BITS + MIX_BITS + 1;
  localparam logic signed [CMP_BITS-1:0] DLY_MIN = CMP_BITS'(256);
  localparam logic signed [CMP_BITS-1:0] DLY_MAX = CMP_BITS'((DEPTH - 1) * 256);
  localparam logic [POS_BITS:0]          SPAN_W  = (POS_BITS + 1)'(DEPTH * 256);
  localparam logic [IDX_BITS-1:0]        LAST    = IDX_BITS'(DEPTH - 1);
  localparam logic signed [MIXP_BITS:0]  SAT_HI  = (MIXP_BITS + 1)'((2 ** (SAMPLE_BITS - 1)) - 1);
  localparam logic signed [MIXP_BITS:0]  SAT_LO  = -SAT_HI - 1;

  sample_t line_mem [DEPTH];

  logic signed [CMP_BITS-1:0] dsum;
  logic [POS_BITS-1:0]        delay;
  logic [POS_BITS-1:0]        delay_next;
  logic [POS_BITS:0]          raw;
  logic [POS_BITS-1:0]        pos;
  logic [POS_BITS-1:0]        pos_next;
  logic [IDX_BITS-1:0]        i0_next;
  logic [IDX_BITS-1:0]        i0;
  logic [IDX_BITS-1:0]        i1;
  logic [7:0]                 frac;
  logic                       v0;
  logic                       v1;
  sample_t                    rd0;
  sample_t                    rd1;
  logic                       v0_q;
  logic                       v1_q;
  logic [7:0]                 frac_q;
  sample_t                    b0;
  sample_t                    b1;
  logic signed [9:0]          w0;
  logic signed [9:0]          w1;
  logic signed [PROD_BITS-1:0] p0;
  logic signed [PROD_BITS-1:0] p1;
  logic signed [PROD_BITS:0]   acc;
  sample_t                    wet;
  logic signed [MIX_BITS:0]   m;
  logic signed [MIX_BITS:0]   wd;
  logic signed [MIXP_BITS-1:0] q0;
  logic signed [MIXP_BITS-1:0] q1;
  logic signed [MIXP_BITS:0]   msum;
  logic signed [MIXP_BITS:0]   scaled;
  sample_t                    result_next;

  // Read delay, clamped to one sample at least and to one sample less than the line length.
  always_comb begin
    dsum = CMP_BITS'(signed'({1'b0, centre})) + CMP_BITS'(offset);
    if (dsum < DLY_MIN) delay_next = POS_BITS'(DLY_MIN);
    else if (dsum > DLY_MAX) delay_next = POS_BITS'(DLY_MAX);
    else delay_next = POS_BITS'(dsum);
  end

  // Read position behind the write pointer, wrapped once around the line.
  always_comb begin
    raw      = {1'b0, wr_index, 8'd0} + SPAN_W - {1'b0, delay};
    pos_next = (raw >= SPAN_W) ? POS_BITS'(raw - SPAN_W) : POS_BITS'(raw);
  end

  assign i0_next = pos[POS_BITS-1:8];

  always_comb begin
    b0 = v0_q ? rd0 : '0;
    b1 = v1_q ? rd1 : '0;
    w0 = 10'sd256 - signed'({2'b00, frac_q});
    w1 = signed'({2'b00, frac_q});
    acc = (PROD_BITS + 1)'(p0) + (PROD_BITS + 1)'(p1) + (PROD_BITS + 1)'(128);
    m   = signed'({1'b0, mix_weight});
    wd  = (MIX_BITS + 1)'(32768) - m;
    msum = (MIXP_BITS + 1)'(q0) + (MIXP_BITS + 1)'(q1) + (MIXP_BITS + 1)'(16384);
    scaled = msum >>> 15;
    if (scaled > SAT_HI) result_next = SAMPLE_BITS'(SAT_HI);
    else if (scaled < SAT_LO) result_next = SAMPLE_BITS'(SAT_LO);
    else result_next = SAMPLE_BITS'(scaled);
  end

  // Entries past the write pointer read as zero until the line has wrapped.
  always_ff @(posedge clk) begin
    delay <= delay_next;
    pos   <= pos_next;
    i0    <= i0_next;
    i1    <= (i0_next == LAST) ? '0 : IDX_BITS'(i0_next + 1'b1);
    frac  <= pos[7:0];
    v0    <= ctrl.wrapped || (i0_next <= wr_index);
    v1    <= ctrl.wrapped || (((i0_next == LAST) ? '0 : IDX_BITS'(i0_next + 1'b1)) <= wr_index);
  end

  always_ff @(posedge clk) begin
    if (ctrl.wr_en) begin
      line_mem[wr_index] <= wr_sample;
    end
    rd0 <= line_mem[i0];
    rd1 <= line_mem[i1];
  end

  always_ff @(posedge clk) begin
    v0_q   <= v0;
    v1_q   <= v1;
    frac_q <= frac;
    p0     <= PROD_BITS'(b0) * PROD_BITS'(w0);
    p1     <= PROD_BITS'(b1) * PROD_BITS'(w1);
    wet    <= SAMPLE_BITS'(acc >>> 8);
    q0     <= MIXP_BITS'(dry) * MIXP_BITS'(wd);
    q1     <= MIXP_BITS'(wet) * MIXP_BITS'(m);
    result <= result_next;
  end

endmodule

[src/scm_merge.sv]
// Output stage: joins the two lane results, or the dry pair on bypass, into
// one registered output item. Depends on scm_pkg.
module scm_merge import scm_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  merge_ctrl_t ctrl,
  input  sample_t     left_mixed,
  input  sample_t     right_mixed,
  input  in_item_t    dry,
  input  logic        out_stall,
  output logic        ready,
  output logic        out_valid,
  output out_item_t   out_item
);

  assign ready = !out_valid || !out_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (ctrl.load) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.load) begin
      if (ctrl.bypass) begin
        out_item.left_out  <= dry.left_in;
        out_item.right_out <= dry.right_in;
      end else begin
        out_item.left_out  <= left_mixed;
        out_item.right_out <= right_mixed;
      end
    end
  end

endmodule

[src/stereo_chorus_modulated_delay.sv]
// Stereo chorus top level. An accepted item runs through the LFO and lane pipelines
// and is then loaded into the output register; a bypassed item (mix zero) goes
// straight from acceptance to the output register. The block takes no new item
// until the last has been handed to the output stage, so each item runs through
// the LFO and lane pipeline alone.
// Reset is synchronous; delay lines are not swept, entries not yet written read
// as zero by tracking the write pointer and a wrapped flag, so no cycles are lost.
module stereo_chorus_modulated_delay import scm_pkg::*; #(
  parameter int LINE_DEPTH       = 1024,
  parameter int SINE_TABLE_DEPTH = 256
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      in_valid,
  output logic                      in_stall,
  input  in_item_t                  in_item,
  output logic                      out_valid,
  input  logic                      out_stall,
  output out_item_t                 out_item,
  input  logic                      cfg_write,
  input  logic [CFG_INDEX_BITS-1:0] cfg_index,
  input  logic [CFG_DATA_BITS-1:0]  cfg_data
);

  localparam int IDX_BITS = $clog2(LINE_DEPTH);
  localparam logic [IDX_BITS-1:0] LAST_INDEX = IDX_BITS'(LINE_DEPTH - 1);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_BUSY,
    ST_DONE
  } state_t;

  state_t                 state;
  logic [CNT_BITS-1:0]    busy_cnt;
  logic                   bypass;
  logic [IDX_BITS-1:0]    wr_index;
  logic                   wrapped;
  logic [STEP_BITS-1:0]   phase;
  in_item_t               dry_item;

  // Configuration registers.
  logic [MIX_BITS-1:0]    mix_amount;
  logic [CENTRE_BITS-1:0] centre_delay;
  logic [DEPTH_BITS-1:0]  sweep_depth;
  logic [STEP_BITS-1:0]   phase_step;

  logic                   in_accept;
  logic                   mix_zero;
  logic [MIX_BITS-1:0]    mix_weight;
  logic                   merge_ready;
  lane_ctrl_t             lane_ctrl;
  merge_ctrl_t            merge_ctrl;
  logic signed [OFFSET_BITS-1:0] lfo_offset;
  logic signed [OFFSET_BITS-1:0] right_offset;
  sample_t                left_mixed;
  sample_t                right_mixed;

  // One item is in flight at a time; the input is held off while it is.
  assign in_stall  = rst || (state != ST_IDLE);
  assign in_accept = in_valid && !in_stall;

  // A mix of zero passes the dry pair through and leaves the delay lines, write pointer and LFO phase untouched.
  // Values above full scale act as fully wet.
  assign mix_zero   = (mix_amount == '0);
  assign mix_weight = (mix_amount > MIX_FULL) ? MIX_FULL : mix_amount;

  // The sample is written into the line on the accepting edge, so the lanes
  // see it before their reads settle.
  assign lane_ctrl.wr_en   = in_accept && !mix_zero;
  assign lane_ctrl.wrapped = wrapped;

  assign merge_ctrl.load   = (state == ST_DONE) && merge_ready;
  assign merge_ctrl.bypass = bypass;

  // The right channel sweeps opposite to the left, i.e. the LFO shifted by pi.
  assign right_offset = -lfo_offset;

  always_ff @(posedge clk) begin
    if (rst) begin
      mix_amount   <= MIX_RESET;
      centre_delay <= CENTRE_RESET;
      sweep_depth  <= DEPTH_RESET;
      phase_step   <= STEP_RESET;
    end else if (cfg_write) begin
      case (cfg_index)
        CFG_MIX:    mix_amount   <= cfg_data[MIX_BITS-1:0];
        CFG_CENTRE: centre_delay <= cfg_data[CENTRE_BITS-1:0];
        CFG_DEPTH:  sweep_depth  <= cfg_data[DEPTH_BITS-1:0];
        CFG_STEP:   phase_step   <= cfg_data[STEP_BITS-1:0];
        default: ;
      endcase
    end
  end

  // Sequencer. The pipelines run freely on held inputs; the write pointer and
  // LFO phase move only when a finished item leaves, so counting the full
  // pipeline depth after acceptance is enough for the lane results to settle.
  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_IDLE;
      busy_cnt <= '0;
      bypass   <= 1'b0;
      wr_index <= '0;
      wrapped  <= 1'b0;
      phase    <= '0;
    end else begin
      case (state)
        ST_IDLE: begin
          if (in_accept) begin
            busy_cnt <= '0;
            bypass   <= mix_zero;
            state    <= mix_zero ? ST_DONE : ST_BUSY;
          end
        end
        ST_BUSY: begin
          if (busy_cnt == CNT_BITS'(PIPE_LATENCY - 1)) begin
            state <= ST_DONE;
          end else begin
            busy_cnt <= busy_cnt + 1'b1;
          end
        end
        ST_DONE: begin
          if (merge_ready) begin
            state <= ST_IDLE;
            if (!bypass) begin
              wr_index <= (wr_index == LAST_INDEX) ? '0 : IDX_BITS'(wr_index + 1'b1);
              wrapped  <= wrapped || (wr_index == LAST_INDEX);
              phase    <= phase + phase_step;
            end
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      dry_item <= in_item;
    end
  end

  scm_lfo #(
    .TABLE_DEPTH (SINE_TABLE_DEPTH)
  ) u_lfo (
    .clk         (clk),
    .phase       (phase),
    .sweep_depth (sweep_depth),
    .offset      (lfo_offset)
  );

  scm_lane #(
    .DEPTH (LINE_DEPTH)
  ) u_lane_left (
    .clk        (clk),
    .ctrl       (lane_ctrl),
    .wr_index   (wr_index),
    .wr_sample  (in_item.left_in),
    .dry        (dry_item.left_in),
    .offset     (lfo_offset),
    .centre     (centre_delay),
    .mix_weight (mix_weight),
    .result     (left_mixed)
  );

  scm_lane #(
    .DEPTH (LINE_DEPTH)
  ) u_lane_right (
    .clk        (clk),
    .ctrl       (lane_ctrl),
    .wr_index   (wr_index),
    .wr_sample  (in_item.right_in),
    .dry        (dry_item.right_in),
    .offset     (right_offset),
    .centre     (centre_delay),
    .mix_weight (mix_weight),
    .result     (right_mixed)
  );

  scm_merge u_merge (
    .clk         (clk),
    .rst         (rst),
    .ctrl        (merge_ctrl),
    .left_mixed  (left_mixed),
    .right_mixed (right_mixed),
    .dry         (dry_item),
    .out_stall   (out_stall),
    .ready       (merge_ready),
    .out_valid   (out_valid),
    .out_item    (out_item)
  );

  // An accepted item always starts work or goes straight to the output stage.
  a_accept_starts: assert property (@(posedge clk) disable iff (rst)
    in_accept |=> (state == ST_BUSY) || (state == ST_DONE))
    else $error("accepted item did not start");

  // Handing a result to the output stage frees the block for the next item.
  a_load_frees: assert property (@(posedge clk) disable iff (rst)
    merge_ctrl.load |=> (state == ST_IDLE))
    else $error("block not idle after result handoff");

  // A finished result waits while the output register is full and stalled.
  a_done_holds: assert property (@(posedge clk) disable iff (rst)
    ((state == ST_DONE) && !merge_ready) |=> (state == ST_DONE) && $stable(phase))
    else $error("finished result dropped while output stalled");

  // The write pointer never leaves the line.
  a_index_range: assert property (@(posedge clk) disable iff (rst)
    wr_index <= LAST_INDEX)
    else $error("write index out of range");

endmodule
